FILE: rtl/sca_pkg.sv
package sca_pkg;

    localparam int SAMPLE_BITS       = 12;
    localparam int FRAC_SHIFT        = 24;
    localparam int TABLE_LEN         = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    // X/Y: |sample diff| scaled by 2^24, grown by the CORDIC gain and sqrt(2), plus sign
    localparam int XW = SAMPLE_BITS + FRAC_SHIFT + 3;
    // Z in 2^-32 turn; the table sum stays below 2^31
    localparam int ZW = 33;

    localparam int ANGLE_W = 17;
    localparam int STEP_W  = 17;
    localparam int SPD_W   = 8;
    localparam int SCALE_W = 17;   // steps_per_degree * 360 <= 91800
    localparam int PROD_W  = ANGLE_W + SCALE_W;

    localparam int IN_TDATA_W  = 4 * SAMPLE_BITS;
    localparam int OUT_TDATA_W = 40;

    localparam int DEG_PER_TURN = 360;
    localparam int SPD_RESET    = 105;

    localparam logic [ANGLE_W-1:0] TURN    = ANGLE_W'(65536);
    localparam logic [ANGLE_W-1:0] HALF    = ANGLE_W'(32768);
    localparam logic [ANGLE_W-1:0] QUARTER = ANGLE_W'(16384);
    localparam logic [ZW-1:0]      ROUND_HALF = ZW'(32768);

    // atan(2^-i) / (2*pi) * 2^32, truncated
    localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // sign and special-case flags that ride along with the CORDIC datapath
    typedef struct packed {
        logic su;         // -x negative
        logic sv;         // -y negative
        logic both_zero;
        logic ax_zero;
        logic ay_zero;
    } t_meta;

endpackage

FILE: rtl/sca_cordic_stage.sv
module sca_cordic_stage
    import sca_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  t_meta                i_meta,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output t_meta                o_meta
);

    localparam logic signed [ZW-1:0] ATAN_I = $signed({1'b0, ATAN_TURNS[STAGE]});

    logic                 r_valid;
    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    t_meta                r_meta;
    logic signed [XW-1:0] w_xs, w_ys;
    logic                 w_ypos;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_xs   = i_x >>> STAGE;
        w_ys   = i_y >>> STAGE;
        w_ypos = !i_y[XW-1] && (|i_y);
        if (w_ypos) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN_I;
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN_I;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_meta <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_meta  = r_meta;

endmodule

FILE: rtl/sincos_sensor_angle_core.sv
// Channel   | Direction | Contents (lowest bit up)
// ----------+-----------+-----------------------------------------------------------
// s_axis    | in        | tdata: cos_pos[11:0] cos_neg[23:12] sin_pos[35:24] sin_neg[47:36]
// m_axis    | out       | tdata: angle_fraction[16:0] step_position[33:17], zeros[39:34]
// i_cfg_*   | in        | motor steps per degree, written when i_cfg_we is high
//
// One request per cycle sustained while m_axis_tready stays high; there is one register
// stage per CORDIC iteration (at most TABLE_LEN) plus prep, angle, multiply, output.
// Reset is synchronous: valid bits clear, the step scale returns to 105 per degree.
// Each stage moves on when the stage after it is empty or moving, so bubbles close up;
// with the output stalled, s_axis_tready drops once every stage holds a request.
module sincos_sensor_angle_core
    import sca_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // cos_pos, cos_neg, sin_pos, sin_neg
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // angle_fraction, step_position
    input  logic                   i_cfg_we,
    input  logic [SPD_W-1:0]       i_cfg_wdata
);

    localparam int N_ST = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    // steps per degree kept premultiplied by 360
    logic [SCALE_W-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_W'(SPD_RESET * DEG_PER_TURN);
        end else if (i_cfg_we) begin
            r_scale <= SCALE_W'(i_cfg_wdata * DEG_PER_TURN);
        end
    end

    // ---------------- prep: differences, magnitudes, flags
    logic [SAMPLE_BITS-1:0] w_cp, w_cn, w_sp, w_sn;
    logic signed [SAMPLE_BITS:0] w_u, w_v, w_nu, w_nv;
    logic [SAMPLE_BITS-1:0] n_p_ax, n_p_ay;
    t_meta                  n_p_meta;
    logic                   r_p_valid;
    logic [SAMPLE_BITS-1:0] r_p_ax, r_p_ay;
    t_meta                  r_p_meta;
    logic                   w_p_ready;

    assign w_cp = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_cn = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_sp = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign w_sn = s_axis_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS];

    always_comb begin
        w_u  = $signed({1'b0, w_cn}) - $signed({1'b0, w_cp});
        w_v  = $signed({1'b0, w_sn}) - $signed({1'b0, w_sp});
        w_nu = -w_u;
        w_nv = -w_v;
        n_p_ax = w_u[SAMPLE_BITS] ? w_nu[SAMPLE_BITS-1:0] : w_u[SAMPLE_BITS-1:0];
        n_p_ay = w_v[SAMPLE_BITS] ? w_nv[SAMPLE_BITS-1:0] : w_v[SAMPLE_BITS-1:0];
        n_p_meta.su        = w_u[SAMPLE_BITS];
        n_p_meta.sv        = w_v[SAMPLE_BITS];
        n_p_meta.ax_zero   = (w_cp == w_cn);
        n_p_meta.ay_zero   = (w_sp == w_sn);
        n_p_meta.both_zero = (w_cp == w_cn) && (w_sp == w_sn);
    end

    // ---------------- CORDIC chain
    logic                 w_valid [N_ST+1];
    logic                 w_ready [N_ST+1];
    logic signed [XW-1:0] w_x     [N_ST+1];
    logic signed [XW-1:0] w_y     [N_ST+1];
    logic signed [ZW-1:0] w_z     [N_ST+1];
    t_meta                w_meta  [N_ST+1];

    assign w_p_ready     = !r_p_valid || w_ready[0];
    assign s_axis_tready = w_p_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_p_ready) begin
            r_p_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_ready && s_axis_tvalid) begin
            r_p_ax   <= n_p_ax;
            r_p_ay   <= n_p_ay;
            r_p_meta <= n_p_meta;
        end
    end

    assign w_valid[0] = r_p_valid;
    assign w_x[0]     = $signed({{(XW-SAMPLE_BITS-FRAC_SHIFT){1'b0}}, r_p_ax,
                                 {FRAC_SHIFT{1'b0}}});
    assign w_y[0]     = $signed({{(XW-SAMPLE_BITS-FRAC_SHIFT){1'b0}}, r_p_ay,
                                 {FRAC_SHIFT{1'b0}}});
    assign w_z[0]     = '0;
    assign w_meta[0]  = r_p_meta;

    for (genvar g = 0; g < N_ST; g++) begin : g_cordic
        sca_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_meta  (w_meta[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_meta  (w_meta[g+1])
        );
    end

    // ---------------- angle: round, clamp, quadrant map
    logic               r_a_valid;
    logic [ANGLE_W-1:0] r_a_angle, n_a_angle;
    logic               w_a_ready;
    logic [ZW-1:0]      w_zr;
    logic [15:0]        w_aq;
    logic [ANGLE_W-1:0] w_a;
    t_meta              w_fm;

    assign w_fm = w_meta[N_ST];

    always_comb begin
        w_zr = w_z[N_ST] + ROUND_HALF;
        w_aq = w_zr[ZW-2:16];
        priority if (w_fm.ay_zero) begin
            w_a = '0;
        end else if (w_fm.ax_zero) begin
            w_a = QUARTER;
        end else if (w_z[N_ST][ZW-1]) begin
            w_a = '0;
        end else if (ANGLE_W'(w_aq) > QUARTER) begin
            w_a = QUARTER;
        end else begin
            w_a = ANGLE_W'(w_aq);
        end

        unique case ({w_fm.su, w_fm.sv})
            2'b00: n_a_angle = w_a;
            2'b10: n_a_angle = HALF - w_a;
            2'b11: n_a_angle = HALF + w_a;
            2'b01: n_a_angle = TURN - w_a;
            default: n_a_angle = w_a;
        endcase

        priority if (w_fm.both_zero) begin
            n_a_angle = HALF;
        end else if (n_a_angle == '0) begin
            n_a_angle = TURN;
        end
    end

    assign w_ready[N_ST] = !r_a_valid || w_a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_ready[N_ST]) begin
            r_a_valid <= w_valid[N_ST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[N_ST] && w_valid[N_ST]) begin
            r_a_angle <= n_a_angle;
        end
    end

    // ---------------- step multiply
    logic               r_m_valid;
    logic [ANGLE_W-1:0] r_m_angle;
    logic [PROD_W-1:0]  r_m_prod;
    logic               w_m_ready;

    assign w_a_ready = !r_m_valid || w_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_a_ready) begin
            r_m_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && r_a_valid) begin
            r_m_angle <= r_a_angle;
            r_m_prod  <= PROD_W'(r_a_angle) * PROD_W'(r_scale);
        end
    end

    // ---------------- output register with step saturation
    logic                  r_o_valid;
    logic [ANGLE_W-1:0]    r_o_angle;
    logic [STEP_W-1:0]     r_o_step, n_o_step;
    logic [PROD_W-17:0]    w_steps;

    assign w_m_ready = !r_o_valid || m_axis_tready;
    assign w_steps   = r_m_prod[PROD_W-1:16];

    always_comb begin
        if (|w_steps[PROD_W-17:STEP_W]) begin
            n_o_step = '1;
        end else begin
            n_o_step = w_steps[STEP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_m_ready) begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_ready && r_m_valid) begin
            r_o_angle <= r_m_angle;
            r_o_step  <= n_o_step;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-ANGLE_W-STEP_W){1'b0}}, r_o_step, r_o_angle};

endmodule

FILE: rtl/sca_checker.sv
module sca_checker
    import sca_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // angle in (0, 65536]
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[ANGLE_W-1:0] != '0) &&
                          (!m_axis_tdata[ANGLE_W-1] || (m_axis_tdata[ANGLE_W-2:0] == '0)))
        else $error("angle out of range");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:ANGLE_W+STEP_W] == '0))
        else $error("pad bits set");

    // empty output stage means every stage can move
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // nothing comes out in the cycle right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind sincos_sensor_angle_core sca_checker u_sca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: test/sincos_sensor_angle_core_checker.sv
`timescale 1ns / 1ps

module sincos_sensor_angle_core_checker
    import sca_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_cfg_we,
    input  logic [SPD_W-1:0]       i_cfg_wdata,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_compared
);

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [STEP_W-1:0]  steps;
    } t_reading;

    localparam longint ANGLE_TURN    = 65536;
    localparam longint ANGLE_HALF    = 32768;
    localparam longint ANGLE_QUARTER = 16384;
    localparam longint STEP_CLAMP    = 131071;

    t_reading         pending_readings[$];
    logic [SPD_W-1:0] steps_per_deg;
    int               error_cnt;
    int               compared_cnt;

    // angle of (-x, -y) as a fraction of a turn, plus the scaled step count
    function automatic t_reading expected_reading(input logic [IN_TDATA_W-1:0] samples,
                                                  input logic [SPD_W-1:0] spd);
        t_reading r;
        longint   du, dv, ax, ay, x, y, z, xs, ys, q, ang, steps;
        du = longint'(samples[SAMPLE_BITS +: SAMPLE_BITS])
           - longint'(samples[0 +: SAMPLE_BITS]);
        dv = longint'(samples[3*SAMPLE_BITS +: SAMPLE_BITS])
           - longint'(samples[2*SAMPLE_BITS +: SAMPLE_BITS]);
        if (du == 0 && dv == 0) begin
            ang = ANGLE_HALF;
        end else begin
            ax = (du < 0) ? -du : du;
            ay = (dv < 0) ? -dv : dv;
            if (ay == 0) begin
                q = 0;
            end else if (ax == 0) begin
                q = ANGLE_QUARTER;
            end else begin
                x = ax <<< FRAC_SHIFT;
                y = ay <<< FRAC_SHIFT;
                z = 0;
                for (int i = 0; i < CORDIC_STAGES_DEF && i < TABLE_LEN; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y > 0) begin
                        x = x + ys;
                        y = y - xs;
                        z = z + longint'({32'b0, ATAN_TURNS[i]});
                    end else begin
                        x = x - ys;
                        y = y + xs;
                        z = z - longint'({32'b0, ATAN_TURNS[i]});
                    end
                end
                if (z < 0) begin
                    q = 0;
                end else begin
                    q = (z + 32768) >>> 16;
                    if (q > ANGLE_QUARTER) q = ANGLE_QUARTER;
                end
            end
            if (du >= 0 && dv >= 0)  ang = q;
            else if (du < 0 && dv >= 0) ang = ANGLE_HALF - q;
            else if (du < 0)         ang = ANGLE_HALF + q;
            else                     ang = ANGLE_TURN - q;
            if (ang == 0) ang = ANGLE_TURN;
        end
        steps = (ang * DEG_PER_TURN * longint'(spd)) >>> 16;
        if (steps > STEP_CLAMP) steps = STEP_CLAMP;
        r.angle = ang[ANGLE_W-1:0];
        r.steps = steps[STEP_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reading want;
        logic [ANGLE_W-1:0] got_angle;
        logic [STEP_W-1:0]  got_steps;
        if (!i_rst_n) begin
            pending_readings.delete();
            steps_per_deg = SPD_W'(SPD_RESET);
            error_cnt     = 0;
            compared_cnt  = 0;
        end else begin
            // results first: outputs are registered, so a result never belongs to this cycle's request
            if (i_m_tvalid && i_m_tready) begin
                got_angle = i_m_tdata[0 +: ANGLE_W];
                got_steps = i_m_tdata[ANGLE_W +: STEP_W];
                if (pending_readings.size() == 0) begin
                    $display("%0t: unexpected result angle=%0d steps=%0d",
                             $time, got_angle, got_steps);
                    error_cnt++;
                end else begin
                    want = pending_readings.pop_front();
                    compared_cnt++;
                    if (got_angle !== want.angle) begin
                        $display("%0t: angle mismatch expected %0d actual %0d",
                                 $time, want.angle, got_angle);
                        error_cnt++;
                    end
                    if (got_steps !== want.steps) begin
                        $display("%0t: step mismatch expected %0d actual %0d",
                                 $time, want.steps, got_steps);
                        error_cnt++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                pending_readings.push_back(expected_reading(i_s_tdata, steps_per_deg));
            if (i_cfg_we)
                steps_per_deg = i_cfg_wdata;
        end
        o_errors   <= error_cnt;
        o_pending  <= pending_readings.size();
        o_compared <= compared_cnt;
    end

endmodule

FILE: test/sincos_sensor_angle_core_tb.sv
`timescale 1ns / 1ps

module sincos_sensor_angle_core_tb;
    import sca_pkg::*;

    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES  = 200;
    localparam logic [SAMPLE_BITS-1:0] S_MAX = '1;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [SPD_W-1:0]       i_cfg_wdata;

    int error_cnt;
    int pending_cnt;
    int compared_cnt;

    bit tx_gaps;
    bit rx_gaps;
    int hold_requests;
    int hold_seen;
    int hold_left;
    int sets_sent;
    int settings_cnt;

    sincos_sensor_angle_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    sincos_sensor_angle_core_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (error_cnt),
        .o_pending   (pending_cnt),
        .o_compared  (compared_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d results outstanding", pending_cnt);
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random back-pressure, plus long hold-offs on request
    initial begin
        m_axis_tready = 1'b0;
        hold_seen     = 0;
        hold_left     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(rx_gaps && $urandom_range(99) < 31);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_samples(input logic [SAMPLE_BITS-1:0] cos_p,
                                input logic [SAMPLE_BITS-1:0] cos_n,
                                input logic [SAMPLE_BITS-1:0] sin_p,
                                input logic [SAMPLE_BITS-1:0] sin_n);
        while (tx_gaps && $urandom_range(99) < 31) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sin_n, sin_p, cos_n, cos_p};
        do @(posedge i_clk); while (!s_axis_tready);
        sets_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_set();
        logic [SAMPLE_BITS-1:0] cp, cn, sp, sn;
        int kind;
        kind = $urandom_range(99);
        cp = SAMPLE_BITS'($urandom);
        cn = SAMPLE_BITS'($urandom);
        sp = SAMPLE_BITS'($urandom);
        sn = SAMPLE_BITS'($urandom);
        if (kind >= 55 && kind < 75) begin
            // near-balanced channels: tiny vectors, fine angles
            cn = cp + SAMPLE_BITS'($urandom_range(6)) - SAMPLE_BITS'(3);
            sn = sp + SAMPLE_BITS'($urandom_range(6)) - SAMPLE_BITS'(3);
        end else if (kind >= 75 && kind < 88) begin
            if ($urandom_range(1)) cn = cp;
            else                   sn = sp;
        end else if (kind >= 88) begin
            cp = $urandom_range(1) ? S_MAX : '0;
            cn = $urandom_range(1) ? S_MAX : '0;
            sp = $urandom_range(1) ? S_MAX : '0;
            sn = $urandom_range(1) ? S_MAX : '0;
        end
        send_samples(cp, cn, sp, sn);
    endtask

    // drop valid, let every result come back, then let the pipe settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_cnt != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // starts right after drain, at a rising edge; ends at a rising edge, after its own drain
    task automatic run_phase(input logic [SPD_W-1:0] spd, input bit gaps,
                             input bit hold, input int count);
        tx_gaps = gaps;
        rx_gaps = gaps;
        if (hold) hold_requests++;
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= spd;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_cnt++;
        repeat (count) send_random_set();
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        tx_gaps       = 1'b0;
        rx_gaps       = 1'b0;
        hold_requests = 0;
        sets_sent     = 0;
        settings_cnt  = 1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset scale; zero vector, axes, corners and tiny vectors
        send_samples('0, '0, '0, '0);
        send_samples(S_MAX, S_MAX, S_MAX, S_MAX);
        send_samples(12'd2048, 12'd2048, 12'd2048, 12'd2048);
        send_samples('0, S_MAX, 12'd100, 12'd100);   // angle zero, reported as full turn
        send_samples(S_MAX, '0, 12'd100, 12'd100);   // half turn
        send_samples(12'd7, 12'd7, '0, S_MAX);       // quarter turn
        send_samples(12'd7, 12'd7, S_MAX, '0);       // three quarters
        send_samples('0, S_MAX, '0, S_MAX);
        send_samples(S_MAX, '0, '0, S_MAX);
        send_samples(S_MAX, '0, S_MAX, '0);
        send_samples('0, S_MAX, S_MAX, '0);
        send_samples(12'd2048, 12'd2049, 12'd2048, 12'd2049);
        send_samples(12'd2049, 12'd2048, 12'd2049, 12'd2048);
        send_samples('0, S_MAX, 12'd2048, 12'd2049);  // near-zero angle, v > 0
        send_samples('0, S_MAX, 12'd2049, 12'd2048);  // near-zero angle, v < 0
        send_samples(12'd2048, 12'd2049, '0, S_MAX);
        send_samples(S_MAX, '0, 12'd2049, 12'd2048);
        send_samples(12'd1, 12'd4094, 12'd2, 12'd4093);
        send_samples(12'hAAA, 12'h555, 12'h555, 12'hAAA);
        send_samples(12'h555, 12'hAAA, 12'hAAA, 12'h555);
        drain();

        run_phase(8'd255, 1'b1, 1'b1, 350);
        run_phase(8'd1, 1'b0, 1'b0, 300);
        run_phase(8'd0, 1'b1, 1'b0, 150);
        run_phase(SPD_W'($urandom_range(2, 254)), 1'b1, 1'b1, 350);
        run_phase(SPD_W'($urandom_range(2, 254)), 1'b1, 1'b0, 300);

        $display("sent %0d sample sets over %0d step scales (incl. 0, 1, 255),",
                 sets_sent, settings_cnt);
        $display("%0d results compared", compared_cnt);
        if (error_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", error_cnt);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/sca_pkg.sv
rtl/sca_cordic_stage.sv
rtl/sincos_sensor_angle_core.sv
rtl/sca_checker.sv
test/sincos_sensor_angle_core_checker.sv
test/sincos_sensor_angle_core_tb.sv
